// ----- rtl/lpds_pkg.sv -----
// ----------------------------------------------------------------------------
// lpds_pkg
// Shared types and constants of the linear probing digest set: result codes,
// the controller command and datapath status groups, and payload widths.
// ----------------------------------------------------------------------------
package lpds_pkg;

    localparam int KEY_WORD_W = 64;
    localparam int KEY_W      = 4 * KEY_WORD_W;
    localparam int CFG_W      = 4;
    localparam int SLOT_IDX_W = 10;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = CFG_W'(10);
    localparam logic             REQ_INSERT      = 1'b0;
    localparam logic             REQ_LOOKUP      = 1'b1;

    typedef enum logic [1:0]
    {
        RES_MISS,
        RES_FOUND,
        RES_INSERTED,
        RES_FULL
    } lpds_res_t;

    typedef struct packed
    {
        logic      clear_step;
        logic      start;
        logic      read;
        logic      advance;
        logic      write_key;
        logic      load_result;
        lpds_res_t res;
    } lpds_cmd_t;

    typedef struct packed
    {
        logic clear_last;
        logic slot_empty;
        logic slot_match;
        logic last_probe;
        logic lookup;
    } lpds_status_t;

endpackage

// ----- rtl/lpds_datapath.sv -----
// ----------------------------------------------------------------------------
// lpds_datapath
// Slot store, probe index and count, key register, slot compare, size
// register and result payload register of the digest set.
// ----------------------------------------------------------------------------
module lpds_datapath
#(
    parameter int MAX_SLOTS_LOG2 = 10
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpds_pkg::lpds_cmd_t           cmd,
    output lpds_pkg::lpds_status_t        status,
    input  logic                          cfg_we,
    input  logic [lpds_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          req_type,
    input  logic [lpds_pkg::KEY_W-1:0]    key,
    output logic [lpds_pkg::OUT_DATA_W-1:0] result
);
    import lpds_pkg::*;

    localparam int DEPTH  = 1 << MAX_SLOTS_LOG2;
    localparam int IDX_W  = MAX_SLOTS_LOG2;
    localparam int WIDE_W = MAX_SLOTS_LOG2 + SLOT_IDX_W;

    logic [KEY_W-1:0]      mem [DEPTH];
    logic [KEY_W-1:0]      rdata_reg;
    logic [KEY_W-1:0]      key_reg;
    logic                  lookup_reg;
    logic [CFG_W-1:0]      size_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      probe_cnt_reg;
    logic [IDX_W-1:0]      clr_cnt_reg;
    logic [IDX_W-1:0]      mask;
    logic [WIDE_W-1:0]     idx_wide;
    logic                  found_reg;
    logic                  inserted_reg;
    logic                  full_reg;
    logic [SLOT_IDX_W-1:0] slot_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [KEY_W-1:0]      mem_wdata;

    // slots in use: size clamped to 1..MAX_SLOTS_LOG2
    always_comb
    begin
        for (int i = 0; i < IDX_W; i++)
        begin
            mask[i] = (i == 0) || (i < int'(size_reg));
        end
    end

    assign idx_wide = WIDE_W'(idx_reg);

    always_comb
    begin
        mem_we    = cmd.clear_step | cmd.write_key;
        mem_waddr = cmd.clear_step ? clr_cnt_reg : idx_reg;
        mem_wdata = cmd.clear_step ? '0 : key_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_LOG2_RESET;
            clr_cnt_reg   <= '0;
            idx_reg       <= '0;
            probe_cnt_reg <= '0;
            lookup_reg    <= REQ_INSERT;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.start)
            begin
                idx_reg       <= key[IDX_W-1:0] & mask;
                probe_cnt_reg <= '0;
                lookup_reg    <= req_type;
            end
            else if (cmd.advance)
            begin
                idx_reg       <= (idx_reg + 1'b1) & mask;
                probe_cnt_reg <= probe_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= key;
        end
        if (cmd.load_result)
        begin
            found_reg    <= (cmd.res == RES_FOUND);
            inserted_reg <= (cmd.res == RES_INSERTED);
            full_reg     <= (cmd.res == RES_FULL);
            slot_reg     <= (cmd.res == RES_FOUND || cmd.res == RES_INSERTED)
                            ? idx_wide[SLOT_IDX_W-1:0] : '0;
        end
    end

    always_comb
    begin
        status.clear_last = (clr_cnt_reg == '1);
        status.slot_empty = (rdata_reg == '0);
        status.slot_match = (rdata_reg == key_reg);
        status.last_probe = (probe_cnt_reg == mask);
        status.lookup     = (lookup_reg == REQ_LOOKUP);
    end

    assign result = OUT_DATA_W'({slot_reg, full_reg, inserted_reg, found_reg});

endmodule

// ----- rtl/lpds_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpds_ctrl
// Controller of the digest set: clearing pass after reset, probe sequencing,
// outcome decision and the output handshake.
// ----------------------------------------------------------------------------
module lpds_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lpds_pkg::lpds_status_t status,
    output lpds_pkg::lpds_cmd_t    cmd,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready
);
    import lpds_pkg::*;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_HOLD
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    lpds_res_t res_reg;
    lpds_res_t res_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      out_free;
    logic      decided;
    lpds_res_t outcome;

    assign out_free = !out_valid_reg || out_ready;

    // outcome of the slot just read
    always_comb
    begin
        decided = 1'b1;
        outcome = RES_MISS;
        if (status.lookup)
        begin
            if (status.slot_match)
            begin
                outcome = RES_FOUND;
            end
            else if (status.slot_empty)
            begin
                outcome = RES_MISS;
            end
            else if (status.last_probe)
            begin
                outcome = RES_FULL;
            end
            else
            begin
                decided = 1'b0;
            end
        end
        else
        begin
            if (status.slot_empty)
            begin
                outcome = RES_INSERTED;
            end
            else if (status.last_probe)
            begin
                outcome = RES_FULL;
            end
            else
            begin
                decided = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res        = outcome;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!decided)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
                else
                begin
                    cmd.write_key = (outcome == RES_INSERTED);
                    if (out_free)
                    begin
                        cmd.load_result = 1'b1;
                        out_valid_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        res_next   = outcome;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                cmd.res = res_reg;
                if (out_free)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            res_reg       <= RES_MISS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/linear_probe_digest_set.sv -----
// ----------------------------------------------------------------------------
// linear_probe_digest_set
// Open-addressing set of 256-bit digests with linear probing: insert and
// lookup over a slot store of 2^MAX_SLOTS_LOG2 entries.
// Each probed slot takes one read and one compare; a request is taken only in
// idle, so a new one waits until the last result is loaded into the output.
// The slot store is read once per probe.
// Reset: a clearing pass zeroes all 2^MAX_SLOTS_LOG2 slots of the store;
// no item is accepted meanwhile, configuration writes are always taken.
// ----------------------------------------------------------------------------
module linear_probe_digest_set
#(
    parameter int MAX_SLOTS_LOG2 = 10
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // key_w0, key_w1, key_w2, key_w3
    input  logic [lpds_pkg::KEY_W-1:0]      s_axis_tdata,
    // req_type
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // found, inserted, table_full, slot_index[9:0], zero fill
    output logic [lpds_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    // size_log2
    input  logic [lpds_pkg::CFG_W-1:0]      cfg_data
);
    import lpds_pkg::*;

    lpds_cmd_t    cmd;
    lpds_status_t status;

    assign cfg_ready = 1'b1;

    lpds_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .cmd       (cmd),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    lpds_datapath
    #(
        .MAX_SLOTS_LOG2 (MAX_SLOTS_LOG2)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .req_type (s_axis_tuser),
        .key      (s_axis_tdata),
        .result   (m_axis_tdata)
    );

endmodule
